// File: src/mcsr_pkg.sv
`timescale 1ns / 1ps

package mcsr_pkg;

    // input item: one midi byte or one command packet
    typedef struct packed {
        logic       operation;
        logic [7:0] midi_byte;
        logic [7:0] command;
        logic [7:0] arg_one;
        logic [7:0] arg_two;
        logic [7:0] arg_three;
        logic [7:0] remote_octet;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] dest_octet;
        logic [2:0] byte_count;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [2:0] op_status;
        logic       last;
    } result_t;

    // operation codes
    localparam logic OP_MIDI    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // command codes
    localparam logic [7:0] CMD_LIST = 8'h08;
    localparam logic [7:0] CMD_DEL  = 8'h0E;
    localparam logic [7:0] CMD_ADD  = 8'h0F;
    localparam logic [7:0] CMD_OUT2 = 8'hA2;
    localparam logic [7:0] CMD_OUT3 = 8'hA3;
    localparam logic [7:0] CMD_SELF = 8'hFF;

    // packet tags
    localparam logic [7:0] TAG_MSG  = 8'hA3;
    localparam logic [7:0] TAG_RUN  = 8'hA2;
    localparam logic [7:0] TAG_LIST = 8'h80;

    // result kinds
    localparam logic [1:0] KIND_SUB    = 2'd0;
    localparam logic [1:0] KIND_LIST   = 2'd1;
    localparam logic [1:0] KIND_MIDI   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // table operation status
    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_NONE  = 3'd4;

    // at most this many results per item
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned NRES_W      = 5;

    // what a table walk is for
    typedef enum logic [2:0] {
        M_MSG  = 3'd0,
        M_RUN  = 3'd1,
        M_LIST = 3'd2,
        M_ADD  = 3'd3,
        M_DEL  = 3'd4
    } mode_t;

    // table status reply
    function automatic result_t mk_status(input logic [7:0] dest, input logic [2:0] st);
        result_t r;
        r            = '0;
        r.kind       = KIND_STATUS;
        r.dest_octet = dest;
        r.op_status  = st;
        r.last       = 1'b1;
        return r;
    endfunction

endpackage

// File: src/mcsr_ram.sv
`timescale 1ns / 1ps

module mcsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/midi_channel_subscription_router.sv
`timescale 1ns / 1ps

// channel   ports                     direction  handshake
// item      start, busy, item         in         taken when start high and busy low
// result    result_valid, result      out        up to 16 results per item, no back-pressure
//
// status bytes, first data bytes, fixed replies and commands rejected at once need no table walk.
// a table walk reads the stored entries in order through a registered table read feeding one
// shared compare unit; a delete also moves each entry after the match down by one.
// rst_n clears the parser flags and the subscription count; table contents need no reset.
// results go out as they are found and cannot be held off by the receiver.

module midi_channel_subscription_router #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mcsr_pkg::in_item_t item,
    output logic              result_valid,
    output mcsr_pkg::result_t result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CHK   = 6'b000100,
        S_FIN   = 6'b001000,
        S_SH_RD = 6'b010000,
        S_SH_WR = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    mcsr_pkg::mode_t      mode_reg, mode_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 have_status_reg, have_status_next;
    logic                 have_first_reg, have_first_next;
    logic [7:0]           status_byte_reg, status_byte_next;
    logic [7:0]           first_data_reg, first_data_next;
    logic [3:0]           source_channel_reg, source_channel_next;
    logic                 pend_valid_reg, pend_valid_next;
    mcsr_pkg::result_t    pend_reg, pend_next;
    logic [mcsr_pkg::NRES_W-1:0] nres_reg, nres_next;
    logic [7:0]           data_reg, data_next;
    logic [7:0]           rem_reg, rem_next;
    logic [15:0]          key_reg, key_next;
    logic                 out_valid_reg, out_valid_next;
    mcsr_pkg::result_t    out_reg, out_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [15:0]          ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [15:0]          rd_data;
    logic [CW-1:0]        idx_inc;
    logic                 hit;
    logic                 full;
    logic                 bad_chan;
    mcsr_pkg::result_t    entry_res;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign idx_inc   = idx_reg + 1'b1;
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign bad_chan  = (item.arg_one[7:4] != 4'd0) || (item.arg_three[7:4] != 4'd0);
    assign ram_raddr = (state_reg == S_SH_RD) ? idx_inc[IW-1:0] : idx_reg[IW-1:0];

    mcsr_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(rd_data)
    );

    // shared compare unit on the entry just read
    always_comb
    begin
        unique case (mode_reg)
            mcsr_pkg::M_MSG,
            mcsr_pkg::M_RUN:  hit = (rd_data[7:4] == source_channel_reg);
            mcsr_pkg::M_LIST: hit = 1'b1;
            mcsr_pkg::M_ADD,
            mcsr_pkg::M_DEL:  hit = (rd_data == key_reg);
            default:          hit = 1'b0;
        endcase
    end

    // result built from the entry just read
    always_comb
    begin
        entry_res      = '0;
        entry_res.kind = mcsr_pkg::KIND_SUB;
        entry_res.dest_octet = rd_data[15:8];
        unique case (mode_reg)
            mcsr_pkg::M_MSG:
            begin
                entry_res.byte_count = 3'd4;
                entry_res.byte_zero  = mcsr_pkg::TAG_MSG;
                entry_res.byte_one   = {status_byte_reg[7:4], rd_data[3:0]};
                entry_res.byte_two   = first_data_reg;
                entry_res.byte_three = data_reg;
            end
            mcsr_pkg::M_RUN:
            begin
                entry_res.byte_count = 3'd3;
                entry_res.byte_zero  = mcsr_pkg::TAG_RUN;
                entry_res.byte_one   = first_data_reg;
                entry_res.byte_two   = data_reg;
            end
            default:
            begin
                entry_res.kind       = mcsr_pkg::KIND_LIST;
                entry_res.dest_octet = rem_reg;
                entry_res.byte_count = 3'd4;
                entry_res.byte_zero  = mcsr_pkg::TAG_LIST;
                entry_res.byte_one   = {4'd0, rd_data[7:4]};
                entry_res.byte_two   = rd_data[15:8];
                entry_res.byte_three = {4'd0, rd_data[3:0]};
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        mode_next           = mode_reg;
        idx_next            = idx_reg;
        count_next          = count_reg;
        have_status_next    = have_status_reg;
        have_first_next     = have_first_reg;
        status_byte_next    = status_byte_reg;
        first_data_next     = first_data_reg;
        source_channel_next = source_channel_reg;
        pend_valid_next     = pend_valid_reg;
        pend_next           = pend_reg;
        nres_next           = nres_reg;
        data_next           = data_reg;
        rem_next            = rem_reg;
        key_next            = key_reg;
        out_valid_next      = 1'b0;
        out_next            = out_reg;
        ram_we              = 1'b0;
        ram_waddr           = idx_reg[IW-1:0];
        ram_wdata           = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next        = '0;
                pend_valid_next = 1'b0;
                nres_next       = '0;
                rem_next        = item.remote_octet;
                if (start)
                begin
                    if (item.operation == mcsr_pkg::OP_MIDI)
                    begin
                        priority if (item.midi_byte[7])
                        begin
                            status_byte_next = item.midi_byte;
                            have_status_next = 1'b1;
                            have_first_next  = 1'b0;
                        end
                        else if (!have_first_reg)
                        begin
                            first_data_next = item.midi_byte;
                            have_first_next = 1'b1;
                        end
                        else
                        begin
                            data_next        = item.midi_byte;
                            have_status_next = 1'b0;
                            have_first_next  = 1'b0;
                            state_next       = S_RD;
                            if (have_status_reg)
                            begin
                                source_channel_next = status_byte_reg[3:0];
                                mode_next           = mcsr_pkg::M_MSG;
                            end
                            else
                            begin
                                mode_next = mcsr_pkg::M_RUN;
                            end
                        end
                    end
                    else
                    begin
                        unique case (item.command)
                            mcsr_pkg::CMD_LIST:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_valid_next      = 1'b1;
                                    out_next            = '0;
                                    out_next.kind       = mcsr_pkg::KIND_LIST;
                                    out_next.dest_octet = item.remote_octet;
                                    out_next.byte_count = 3'd4;
                                    out_next.byte_zero  = mcsr_pkg::TAG_LIST;
                                    out_next.byte_one   = 8'hFF;
                                    out_next.byte_three = 8'hFF;
                                    out_next.last       = 1'b1;
                                end
                                else
                                begin
                                    mode_next  = mcsr_pkg::M_LIST;
                                    state_next = S_RD;
                                end
                            end
                            mcsr_pkg::CMD_DEL:
                            begin
                                key_next = {item.arg_two, item.arg_one[3:0],
                                            item.arg_three[3:0]};
                                if (bad_chan)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = mcsr_pkg::mk_status(item.remote_octet,
                                                                   mcsr_pkg::ST_RANGE);
                                end
                                else
                                begin
                                    mode_next  = mcsr_pkg::M_DEL;
                                    state_next = S_RD;
                                end
                            end
                            mcsr_pkg::CMD_ADD:
                            begin
                                key_next = {item.arg_two, item.arg_one[3:0],
                                            item.arg_three[3:0]};
                                priority if (full)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = mcsr_pkg::mk_status(item.remote_octet,
                                                                   mcsr_pkg::ST_FULL);
                                end
                                else if (bad_chan)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = mcsr_pkg::mk_status(item.remote_octet,
                                                                   mcsr_pkg::ST_RANGE);
                                end
                                else
                                begin
                                    mode_next  = mcsr_pkg::M_ADD;
                                    state_next = S_RD;
                                end
                            end
                            mcsr_pkg::CMD_SELF:
                            begin
                                key_next = {item.remote_octet, 8'h00};
                                if (full)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = mcsr_pkg::mk_status(item.remote_octet,
                                                                   mcsr_pkg::ST_FULL);
                                end
                                else
                                begin
                                    mode_next  = mcsr_pkg::M_ADD;
                                    state_next = S_RD;
                                end
                            end
                            mcsr_pkg::CMD_OUT2:
                            begin
                                out_valid_next      = 1'b1;
                                out_next            = '0;
                                out_next.kind       = mcsr_pkg::KIND_MIDI;
                                out_next.byte_count = 3'd2;
                                out_next.byte_zero  = item.arg_one;
                                out_next.byte_one   = item.arg_two;
                                out_next.last       = 1'b1;
                            end
                            mcsr_pkg::CMD_OUT3:
                            begin
                                out_valid_next      = 1'b1;
                                out_next            = '0;
                                out_next.kind       = mcsr_pkg::KIND_MIDI;
                                out_next.byte_count = 3'd3;
                                out_next.byte_zero  = item.arg_one;
                                out_next.byte_one   = item.arg_two;
                                out_next.byte_two   = item.arg_three;
                                out_next.last       = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            // issue the read of the next entry, or finish the walk
            S_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end

            // entry data is here
            S_CHK:
            begin
                idx_next   = idx_inc;
                state_next = S_RD;
                unique case (mode_reg)
                    mcsr_pkg::M_ADD:
                    begin
                        if (hit)
                        begin
                            out_valid_next = 1'b1;
                            out_next = mcsr_pkg::mk_status(rem_reg, mcsr_pkg::ST_DUP);
                            state_next = S_IDLE;
                        end
                    end
                    mcsr_pkg::M_DEL:
                    begin
                        if (hit)
                        begin
                            idx_next   = idx_reg;
                            state_next = S_SH_RD;
                        end
                    end
                    default:
                    begin
                        // hold one result back so the final one can be marked
                        if (hit && (nres_reg < mcsr_pkg::NRES_W'(mcsr_pkg::MAX_RESULTS)))
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = pend_reg;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = entry_res;
                            nres_next       = nres_reg + 1'b1;
                        end
                    end
                endcase
            end

            // end of walk
            S_FIN:
            begin
                state_next = S_IDLE;
                unique case (mode_reg)
                    mcsr_pkg::M_ADD:
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = count_reg[IW-1:0];
                        ram_wdata      = key_reg;
                        count_next     = count_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_next = mcsr_pkg::mk_status(rem_reg, mcsr_pkg::ST_DONE);
                    end
                    mcsr_pkg::M_DEL:
                    begin
                        out_valid_next = 1'b1;
                        out_next = mcsr_pkg::mk_status(rem_reg, mcsr_pkg::ST_NONE);
                    end
                    default:
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_next.last  = 1'b1;
                        end
                    end
                endcase
            end

            // move the following entry down by one
            S_SH_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next     = count_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_next   = mcsr_pkg::mk_status(rem_reg, mcsr_pkg::ST_DONE);
                    state_next = S_IDLE;
                end
            end

            S_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = rd_data;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            count_reg          <= '0;
            have_status_reg    <= 1'b0;
            have_first_reg     <= 1'b0;
            status_byte_reg    <= '0;
            first_data_reg     <= '0;
            source_channel_reg <= '0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            have_status_reg    <= have_status_next;
            have_first_reg     <= have_first_next;
            status_byte_reg    <= status_byte_next;
            first_data_reg     <= first_data_next;
            source_channel_reg <= source_channel_next;
            pend_valid_reg     <= pend_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        nres_reg <= nres_next;
        data_reg <= data_next;
        rem_reg  <= rem_next;
        key_reg  <= key_next;
        out_reg  <= out_next;
    end

endmodule

// File: tb/mcsr_checker.sv
`timescale 1ns / 1ps

module mcsr_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  mcsr_pkg::in_item_t  item,
    input  logic                result_valid,
    input  mcsr_pkg::result_t   result,
    output int                  fail_count,
    output int                  pending_count
);

    localparam int DEPTH = 16;

    // predicted router state
    logic [15:0] subs [DEPTH];
    int unsigned n_subs;
    logic        got_status;
    logic        got_first;
    logic [7:0]  status_reg;
    logic [7:0]  first_reg;
    logic [3:0]  run_channel;

    mcsr_pkg::result_t expected_results [$];
    mcsr_pkg::result_t step_out [$];

    assign pending_count = expected_results.size();

    // one mismatch line and count
    task automatic report_mismatch(input string what, input mcsr_pkg::result_t got,
                                   input mcsr_pkg::result_t want);
        $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
        fail_count++;
    endtask

    function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
                                        input logic [2:0] c, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3, input logic [2:0] st);
        mcsr_pkg::result_t r;
        if (step_out.size() >= mcsr_pkg::MAX_RESULTS) return;
        r = '0;
        r.kind = k; r.dest_octet = d; r.byte_count = c;
        r.byte_zero = b0; r.byte_one = b1; r.byte_two = b2; r.byte_three = b3;
        r.op_status = st;
        step_out.push_back(r);
    endfunction

    function automatic logic [2:0] table_add(input logic [7:0] src, input logic [7:0] oct,
                                             input logic [7:0] dst);
        logic [15:0] entry;
        if (n_subs >= DEPTH) return mcsr_pkg::ST_FULL;
        if (src > 15 || dst > 15) return mcsr_pkg::ST_RANGE;
        entry = {oct, src[3:0], dst[3:0]};
        for (int i = 0; i < n_subs; i++)
            if (subs[i] == entry) return mcsr_pkg::ST_DUP;
        subs[n_subs] = entry;
        n_subs++;
        return mcsr_pkg::ST_DONE;
    endfunction

    function automatic logic [2:0] table_delete(input logic [7:0] src, input logic [7:0] oct,
                                                input logic [7:0] dst);
        logic [15:0] entry;
        if (src > 15 || dst > 15) return mcsr_pkg::ST_RANGE;
        entry = {oct, src[3:0], dst[3:0]};
        for (int i = 0; i < n_subs; i++)
            if (subs[i] == entry)
            begin
                for (int j = i; j + 1 < n_subs; j++) subs[j] = subs[j + 1];
                n_subs--;
                return mcsr_pkg::ST_DONE;
            end
        return mcsr_pkg::ST_NONE;
    endfunction

    // work out the results of one accepted item
    function automatic void route_item(input mcsr_pkg::in_item_t it);
        step_out.delete();
        if (it.operation == mcsr_pkg::OP_MIDI)
        begin
            if (it.midi_byte[7])
            begin
                status_reg = it.midi_byte;
                got_status = 1'b1;
                got_first  = 1'b0;
            end
            else if (!got_first)
            begin
                first_reg = it.midi_byte;
                got_first = 1'b1;
            end
            else if (got_status)
            begin
                run_channel = status_reg[3:0];
                for (int i = 0; i < n_subs; i++)
                    if (subs[i][7:4] == run_channel)
                        push_result(mcsr_pkg::KIND_SUB, subs[i][15:8], 3'd4, mcsr_pkg::TAG_MSG,
                                    {status_reg[7:4], subs[i][3:0]}, first_reg,
                                    it.midi_byte, mcsr_pkg::ST_DONE);
                got_status = 1'b0;
                got_first  = 1'b0;
            end
            else
            begin
                for (int i = 0; i < n_subs; i++)
                    if (subs[i][7:4] == run_channel)
                        push_result(mcsr_pkg::KIND_SUB, subs[i][15:8], 3'd3, mcsr_pkg::TAG_RUN,
                                    first_reg, it.midi_byte, 8'h00, mcsr_pkg::ST_DONE);
                got_first = 1'b0;
            end
        end
        else
        begin
            case (it.command)
                mcsr_pkg::CMD_LIST:
                begin
                    if (n_subs == 0)
                        push_result(mcsr_pkg::KIND_LIST, it.remote_octet, 3'd4,
                                    mcsr_pkg::TAG_LIST, 8'hFF, 8'h00, 8'hFF,
                                    mcsr_pkg::ST_DONE);
                    for (int i = 0; i < n_subs; i++)
                        push_result(mcsr_pkg::KIND_LIST, it.remote_octet, 3'd4,
                                    mcsr_pkg::TAG_LIST,
                                    {4'h0, subs[i][7:4]}, subs[i][15:8],
                                    {4'h0, subs[i][3:0]}, mcsr_pkg::ST_DONE);
                end
                mcsr_pkg::CMD_DEL:
                    push_result(mcsr_pkg::KIND_STATUS, it.remote_octet, 3'd0, 8'h00, 8'h00,
                                8'h00, 8'h00,
                                table_delete(it.arg_one, it.arg_two, it.arg_three));
                mcsr_pkg::CMD_ADD:
                    push_result(mcsr_pkg::KIND_STATUS, it.remote_octet, 3'd0, 8'h00, 8'h00,
                                8'h00, 8'h00,
                                table_add(it.arg_one, it.arg_two, it.arg_three));
                mcsr_pkg::CMD_OUT2:
                    push_result(mcsr_pkg::KIND_MIDI, 8'h00, 3'd2, it.arg_one, it.arg_two,
                                8'h00, 8'h00, mcsr_pkg::ST_DONE);
                mcsr_pkg::CMD_OUT3:
                    push_result(mcsr_pkg::KIND_MIDI, 8'h00, 3'd3, it.arg_one, it.arg_two,
                                it.arg_three, 8'h00, mcsr_pkg::ST_DONE);
                mcsr_pkg::CMD_SELF:
                    push_result(mcsr_pkg::KIND_STATUS, it.remote_octet, 3'd0, 8'h00, 8'h00,
                                8'h00, 8'h00,
                                table_add(8'h00, it.remote_octet, 8'h00));
                default: ;
            endcase
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endfunction

    // watch both channels on every rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_subs      <= 0;
            got_status  <= 1'b0;
            got_first   <= 1'b0;
            status_reg  <= 8'h00;
            first_reg   <= 8'h00;
            run_channel <= 4'h0;
            fail_count  <= 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", result, '0);
                else
                begin
                    mcsr_pkg::result_t want;
                    want = expected_results.pop_front();
                    if (result.kind != want.kind) report_mismatch("kind", result, want);
                    if (result.dest_octet != want.dest_octet)
                        report_mismatch("dest_octet", result, want);
                    if (result.byte_count != want.byte_count)
                        report_mismatch("byte_count", result, want);
                    if (result.byte_zero != want.byte_zero)
                        report_mismatch("byte_zero", result, want);
                    if (result.byte_one != want.byte_one)
                        report_mismatch("byte_one", result, want);
                    if (result.byte_two != want.byte_two)
                        report_mismatch("byte_two", result, want);
                    if (result.byte_three != want.byte_three)
                        report_mismatch("byte_three", result, want);
                    if (result.op_status != want.op_status)
                        report_mismatch("op_status", result, want);
                    if (result.last != want.last) report_mismatch("last", result, want);
                end
            end
            if (start && !busy) route_item(item);
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    mcsr_pkg::in_item_t  item;
    logic                result_valid;
    mcsr_pkg::result_t   result;
    int                  fail_count;
    int                  pending_count;
    int                  idle_cycles;
    int                  gap_pct;

    midi_channel_subscription_router uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result)
    );

    mcsr_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // hand one item over, with a random gap first; start stays up for a following item
    task automatic send_item(input mcsr_pkg::in_item_t it);
        while ($urandom_range(99, 0) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_midi(input logic [7:0] b);
        mcsr_pkg::in_item_t it;
        it = mcsr_pkg::in_item_t'({$urandom, $urandom});
        it.operation = mcsr_pkg::OP_MIDI;
        it.midi_byte = b;
        send_item(it);
    endtask

    task automatic send_command(input logic [7:0] c, input logic [7:0] a1,
                                input logic [7:0] a2, input logic [7:0] a3,
                                input logic [7:0] rem);
        mcsr_pkg::in_item_t it;
        it = mcsr_pkg::in_item_t'({$urandom, $urandom});
        it.operation = mcsr_pkg::OP_COMMAND;
        it.command = c; it.arg_one = a1; it.arg_two = a2; it.arg_three = a3;
        it.remote_octet = rem;
        send_item(it);
    endtask

    // mostly well-formed traffic on a small channel set
    task automatic random_item();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(99, 0);
        if (pick < 30)
            send_midi({1'b1, 3'($urandom_range(7, 0)), 1'b0, 3'($urandom_range(3, 0))});
        else if (pick < 62) send_midi({1'b0, 7'($urandom)});
        else if (pick < 66) send_midi(rnd8());
        else if (pick < 78)
            send_command(mcsr_pkg::CMD_ADD,
                         $urandom_range(9, 0) < 8 ? 8'($urandom_range(3, 0)) : rnd8(),
                         $urandom_range(3, 0) == 0 ? rnd8() : 8'($urandom_range(3, 0)),
                         $urandom_range(9, 0) < 8 ? 8'($urandom_range(15, 0)) : rnd8(),
                         rnd8());
        else if (pick < 88)
            send_command(mcsr_pkg::CMD_DEL,
                         $urandom_range(9, 0) < 8 ? 8'($urandom_range(3, 0)) : rnd8(),
                         $urandom_range(3, 0) == 0 ? rnd8() : 8'($urandom_range(3, 0)),
                         $urandom_range(9, 0) < 8 ? 8'($urandom_range(15, 0)) : rnd8(),
                         rnd8());
        else if (pick < 91)
            send_command(mcsr_pkg::CMD_LIST, rnd8(), rnd8(), rnd8(), rnd8());
        else if (pick < 93)
            send_command(mcsr_pkg::CMD_SELF, rnd8(), rnd8(), rnd8(), rnd8());
        else if (pick < 95)
            send_command(mcsr_pkg::CMD_OUT2, rnd8(), rnd8(), rnd8(), rnd8());
        else if (pick < 97)
            send_command(mcsr_pkg::CMD_OUT3, rnd8(), rnd8(), rnd8(), rnd8());
        else
        begin
            b = rnd8();
            send_command(b, rnd8(), rnd8(), rnd8(), rnd8());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        idle_cycles = 0;
        gap_pct     = 25;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, running status from reset, table limits
        send_command(mcsr_pkg::CMD_LIST, 8'h00, 8'h00, 8'h00, 8'h00);
        send_midi(8'h00);
        send_midi(8'h7F);
        send_command(mcsr_pkg::CMD_SELF, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_command(mcsr_pkg::CMD_SELF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(mcsr_pkg::CMD_ADD, 8'h10, 8'h01, 8'h00, 8'h01);
        send_command(mcsr_pkg::CMD_ADD, 8'h00, 8'h01, 8'h10, 8'h01);
        send_command(mcsr_pkg::CMD_ADD, 8'h0F, 8'h00, 8'h0F, 8'h02);
        send_command(mcsr_pkg::CMD_DEL, 8'h0F, 8'h00, 8'hFF, 8'h02);
        send_command(mcsr_pkg::CMD_DEL, 8'h01, 8'h09, 8'h01, 8'h02);
        send_midi(8'h05);
        send_midi(8'h06);
        send_midi(8'h9F);
        send_midi(8'h11);
        send_midi(8'hFF);
        send_midi(8'h40);
        send_midi(8'h7F);
        send_midi(8'h00);
        send_midi(8'h01);
        send_command(mcsr_pkg::CMD_OUT2, 8'hFF, 8'h00, 8'hAA, 8'h00);
        send_command(mcsr_pkg::CMD_OUT3, 8'h00, 8'hFF, 8'h55, 8'h00);
        send_command(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(mcsr_pkg::CMD_DEL, 8'h0F, 8'h00, 8'h0F, 8'h02);
        send_command(mcsr_pkg::CMD_DEL, 8'h0F, 8'h00, 8'h0F, 8'h02);
        for (int i = 0; i < 17; i++)
            send_command(mcsr_pkg::CMD_ADD, 8'h00, i[7:0], 8'h0F, 8'h03);
        send_command(mcsr_pkg::CMD_LIST, 8'h00, 8'h00, 8'h00, 8'h04);
        send_midi(8'h90);
        send_midi(8'h3C);
        send_midi(8'h64);
        send_midi(8'h3C);
        send_midi(8'h00);

        // hold off until the table is quiet
        start <= 1'b0;
        wait (pending_count == 0);
        repeat (80) @(posedge clk);
        for (int i = 0; i < 17; i++)
            send_command(mcsr_pkg::CMD_DEL, 8'h00, i[7:0], 8'h0F, 8'h03);

        // random phases: sender gaps, then longer sender gaps, then none
        for (int i = 0; i < 350; i++)
        begin
            if (i == 117) gap_pct = 64;
            if (i == 234) gap_pct = 0;
            random_item();
        end

        start <= 1'b0;
        wait (pending_count == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
